/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RPE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/rpe_pkg.sv */
// ----------------------------------------------------------------------------
// rpe_pkg
// types and constants of the resp ip/port extractor
// ----------------------------------------------------------------------------
package rpe_pkg;

    localparam int MAX_ADDR_LEN = 64;
    localparam int ADDR_FILL_W  = $clog2(MAX_ADDR_LEN + 1);

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] KEY_IP   = 32'h0000_7069;
    localparam logic [31:0] KEY_PORT = 32'h7472_6F70;

    localparam logic [1:0] END_NONE  = 2'd0;
    localparam logic [1:0] END_DONE  = 2'd1;
    localparam logic [1:0] END_ERROR = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_COUNT,
        PH_COUNT_LF,
        PH_ARG,
        PH_ARG_LEN,
        PH_ARG_LEN_LF,
        PH_SUB_ARRAY,
        PH_BODY,
        PH_BODY_LF,
        PH_INVALID,
        PH_FINISHED
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_reply;
    } t_in_item;

    typedef struct packed {
        logic       addr_valid;
        logic [7:0] addr_char;
        logic       addr_complete;
        logic [1:0] end_status;
    } t_out_item;

    typedef struct packed {
        t_phase                 parse_phase;
        logic                   count_nonzero;
        logic [2:0]             field_length;
        logic                   in_ip_value;
        logic                   in_port_value;
        logic [31:0]            key_chars;
        logic [2:0]             key_fill;
        logic [ADDR_FILL_W-1:0] addr_fill;
    } t_state;

    localparam t_state STATE_RESET = '{
        parse_phase:   PH_IDLE,
        count_nonzero: 1'b0,
        field_length:  3'd0,
        in_ip_value:   1'b0,
        in_port_value: 1'b0,
        key_chars:     32'd0,
        key_fill:      3'd0,
        addr_fill:     '0
    };

endpackage

/* src/rpe_parser_step.sv */
// ----------------------------------------------------------------------------
// rpe_parser_step
// next-state and result logic for one byte of the reply stream
// ----------------------------------------------------------------------------
module rpe_parser_step (
    input  rpe_pkg::t_state    i_state,
    input  rpe_pkg::t_in_item  i_item,
    output rpe_pkg::t_state    o_state,
    output rpe_pkg::t_out_item o_result
);
    import rpe_pkg::*;

    logic [7:0]             c;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [2:0]             len_next;
    logic                   can_emit;
    logic [ADDR_FILL_W-1:0] fill_inc;
    logic                   key_is_ip;
    logic                   key_is_port;
    t_state                 s;
    t_out_item              r;

    assign c           = i_item.data_byte;
    assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit       = c[3:0];
    assign len_next    = (i_state.field_length != 3'd0) ? 3'd7 :
                         ((digit > 4'd7) ? 3'd7 : digit[2:0]);
    assign can_emit    = i_state.addr_fill < ADDR_FILL_W'(MAX_ADDR_LEN);
    assign fill_inc    = i_state.addr_fill + ADDR_FILL_W'(1);
    assign key_is_ip   = (i_state.field_length == 3'd2) && (i_state.key_fill == 3'd2)
                         && (i_state.key_chars == KEY_IP);
    assign key_is_port = (i_state.field_length == 3'd4) && (i_state.key_fill == 3'd4)
                         && (i_state.key_chars == KEY_PORT);

    always_comb begin
        s = i_state;
        r = '{addr_valid: 1'b0, addr_char: 8'd0, addr_complete: 1'b0,
              end_status: END_NONE};
        case (i_state.parse_phase)
            PH_IDLE: begin
                s.parse_phase = (c == CH_STAR) ? PH_COUNT : PH_INVALID;
            end
            PH_COUNT: begin
                if (is_digit) begin
                    if (c != CH_ZERO) begin
                        s.count_nonzero = 1'b1;
                    end
                end else if (c == CH_CR) begin
                    s.parse_phase = i_state.count_nonzero ? PH_COUNT_LF : PH_FINISHED;
                end else begin
                    s.parse_phase = PH_INVALID;
                end
            end
            PH_COUNT_LF: begin
                s.parse_phase = (c == CH_LF) ? PH_ARG : PH_INVALID;
            end
            PH_ARG: begin
                if (c == CH_DOLLAR) begin
                    s.parse_phase  = PH_ARG_LEN;
                    s.field_length = 3'd0;
                end else if (c == CH_STAR) begin
                    s.parse_phase = PH_SUB_ARRAY;
                end else begin
                    s.parse_phase = PH_INVALID;
                end
            end
            PH_ARG_LEN: begin
                if (is_digit) begin
                    s.field_length = len_next;
                end else if (c == CH_CR) begin
                    s.parse_phase = PH_ARG_LEN_LF;
                end else begin
                    s.parse_phase = PH_INVALID;
                end
            end
            PH_ARG_LEN_LF: begin
                s.parse_phase = (c == CH_LF) ? PH_BODY : PH_INVALID;
            end
            PH_SUB_ARRAY: begin
                if (c == CH_LF) begin
                    s.parse_phase = PH_ARG;
                end
            end
            PH_BODY: begin
                if (c == CH_CR) begin
                    s.parse_phase = PH_BODY_LF;
                    if (i_state.in_port_value) begin
                        s.in_port_value = 1'b0;
                        r.addr_complete = 1'b1;
                        s.addr_fill     = '0;
                    end else if (i_state.in_ip_value) begin
                        s.in_ip_value = 1'b0;
                        if (can_emit) begin
                            r.addr_valid = 1'b1;
                            r.addr_char  = CH_COLON;
                            s.addr_fill  = fill_inc;
                        end
                    end else if (key_is_ip) begin
                        s.in_ip_value = 1'b1;
                    end else if (key_is_port) begin
                        s.in_port_value = 1'b1;
                    end
                end else if (i_state.in_ip_value || i_state.in_port_value) begin
                    if (can_emit) begin
                        r.addr_valid = 1'b1;
                        r.addr_char  = c;
                        s.addr_fill  = fill_inc;
                    end
                end else if ((i_state.field_length == 3'd2)
                             || (i_state.field_length == 3'd4)) begin
                    if (i_state.key_fill < 3'd4) begin
                        case (i_state.key_fill[1:0])
                            2'd0:    s.key_chars[7:0]   = c;
                            2'd1:    s.key_chars[15:8]  = c;
                            2'd2:    s.key_chars[23:16] = c;
                            default: s.key_chars[31:24] = c;
                        endcase
                        s.key_fill = i_state.key_fill + 3'd1;
                    end
                end
            end
            PH_BODY_LF: begin
                s.key_chars   = 32'd0;
                s.key_fill    = 3'd0;
                s.parse_phase = (c == CH_LF) ? PH_ARG : PH_INVALID;
            end
            default: begin
            end
        endcase
        if (i_item.end_of_reply) begin
            r.end_status = (s.parse_phase == PH_INVALID) ? END_ERROR : END_DONE;
            s = STATE_RESET;
        end
    end

    assign o_state  = s;
    assign o_result = r;

endmodule

/* src/resp_ip_port_extractor_core.sv */
// the result of an accepted byte is registered in the output register
// throughput: one byte per cycle while i_stall is low, limited only by the single output register
// o_stall rises only while a result is held and i_stall is high
// reset: synchronous active-low i_rst_n returns the parser to idle and empties the output
// ----------------------------------------------------------------------------
// resp_ip_port_extractor_core
// streaming resp array parser that extracts an ip:port address
// ----------------------------------------------------------------------------
module resp_ip_port_extractor_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rpe_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output rpe_pkg::t_out_item o_data
);
    import rpe_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      accept;

    rpe_parser_step u_step (
        .i_state  (r_state),
        .i_item   (i_data),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* src/rpe_checker.sv */
// ----------------------------------------------------------------------------
// rpe_checker
// port-level checks on the resp ip/port extractor
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input rpe_pkg::t_out_item o_data
);
    import rpe_pkg::*;

    logic out_held;
    logic char_clear;
    logic status_ok;

    assign out_held   = o_valid && i_stall;
    assign char_clear = o_data.addr_valid || (o_data.addr_char == 8'd0);
    assign status_ok  = ((o_data.end_status == END_NONE) || (o_data.end_status == END_DONE)
                         || (o_data.end_status == END_ERROR))
                        && !(o_data.addr_complete && o_data.addr_valid);

    `RPE_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid, "output valid after reset")
    `RPE_ASSERT(a_hold, out_held |=> o_valid && $stable(o_data), "stalled output changed")
    `RPE_ASSERT(a_no_stall_empty, !o_valid |-> !o_stall, "stall with empty output")
    `RPE_ASSERT(a_char_zero, o_valid |-> char_clear, "stray char")
    `RPE_ASSERT(a_status, o_valid |-> status_ok, "bad result")

endmodule

bind resp_ip_port_extractor_core rpe_checker u_rpe_checker (.*);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// streams generated resp array replies byte by byte through the ip:port
// extractor, predicts every result transaction and checks it field by field
// under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rpe_pkg::*;

    localparam int CALM_TAIL      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 100;

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      i_valid  = 1'b0;
    logic      i_stall  = 1'b0;
    t_in_item  i_data   = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;

    t_in_item   byte_q[$];
    t_out_item  expected_q[$];
    logic [7:0] reply_bytes[$];
    t_state     parser      = STATE_RESET;
    logic       in_fire     = 1'b0;
    int         send_gap    = 0;
    int         stall_gap   = 0;
    int         idle_cycles = 0;
    int         err_count   = 0;

    resp_ip_port_extractor_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial forever #5 i_clk = ~i_clk;

    // expected result of one byte, advancing the parser copy
    function automatic t_out_item parse_byte(input t_in_item item);
        t_out_item  res;
        logic [7:0] c;
        logic [7:0] emit_c;
        logic       do_emit;
        logic       digit;
        int         v;
        res     = '0;
        c       = item.data_byte;
        emit_c  = '0;
        do_emit = 1'b0;
        digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        case (parser.parse_phase)
            PH_IDLE: begin
                parser.parse_phase = (c == CH_STAR) ? PH_COUNT : PH_INVALID;
            end
            PH_COUNT: begin
                if (digit) begin
                    if (c != CH_ZERO)
                        parser.count_nonzero = 1'b1;
                end else if (c == CH_CR) begin
                    parser.parse_phase = parser.count_nonzero ? PH_COUNT_LF : PH_FINISHED;
                end else begin
                    parser.parse_phase = PH_INVALID;
                end
            end
            PH_COUNT_LF: begin
                parser.parse_phase = (c == CH_LF) ? PH_ARG : PH_INVALID;
            end
            PH_ARG: begin
                if (c == CH_DOLLAR) begin
                    parser.parse_phase  = PH_ARG_LEN;
                    parser.field_length = 3'd0;
                end else if (c == CH_STAR) begin
                    parser.parse_phase = PH_SUB_ARRAY;
                end else begin
                    parser.parse_phase = PH_INVALID;
                end
            end
            PH_ARG_LEN: begin
                if (digit) begin
                    v = parser.field_length * 10 + (c - CH_ZERO);
                    parser.field_length = (v > 7) ? 3'd7 : v[2:0];
                end else if (c == CH_CR) begin
                    parser.parse_phase = PH_ARG_LEN_LF;
                end else begin
                    parser.parse_phase = PH_INVALID;
                end
            end
            PH_ARG_LEN_LF: begin
                parser.parse_phase = (c == CH_LF) ? PH_BODY : PH_INVALID;
            end
            PH_SUB_ARRAY: begin
                if (c == CH_LF)
                    parser.parse_phase = PH_ARG;
            end
            PH_BODY: begin
                if (c == CH_CR) begin
                    parser.parse_phase = PH_BODY_LF;
                    if (parser.in_port_value) begin
                        parser.in_port_value = 1'b0;
                        res.addr_complete    = 1'b1;
                        parser.addr_fill     = '0;
                    end else if (parser.in_ip_value) begin
                        parser.in_ip_value = 1'b0;
                        do_emit = 1'b1;
                        emit_c  = CH_COLON;
                    end else if (parser.field_length == 3'd2 && parser.key_fill == 3'd2
                                 && parser.key_chars == KEY_IP) begin
                        parser.in_ip_value = 1'b1;
                    end else if (parser.field_length == 3'd4 && parser.key_fill == 3'd4
                                 && parser.key_chars == KEY_PORT) begin
                        parser.in_port_value = 1'b1;
                    end
                end else if (parser.in_ip_value || parser.in_port_value) begin
                    do_emit = 1'b1;
                    emit_c  = c;
                end else if (parser.field_length == 3'd2 || parser.field_length == 3'd4) begin
                    if (parser.key_fill < 3'd4) begin
                        parser.key_chars[8*parser.key_fill +: 8] = c;
                        parser.key_fill++;
                    end
                end
            end
            PH_BODY_LF: begin
                parser.key_chars   = '0;
                parser.key_fill    = '0;
                parser.parse_phase = (c == CH_LF) ? PH_ARG : PH_INVALID;
            end
            default: begin
            end
        endcase
        if (do_emit && parser.addr_fill < MAX_ADDR_LEN) begin
            parser.addr_fill++;
            res.addr_valid = 1'b1;
            res.addr_char  = emit_c;
        end
        if (item.end_of_reply) begin
            res.end_status = (parser.parse_phase == PH_INVALID) ? END_ERROR : END_DONE;
            parser = STATE_RESET;
        end
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        reply_bytes.insert(reply_bytes.size(), b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // array or bulk header, sometimes with a leading zero
    task automatic put_len(input string lead, input int n);
        string pad;
        pad = ($urandom_range(0, 15) == 0) ? "0" : "";
        put_text({lead, pad, $sformatf("%0d", n), "\r\n"});
    endtask

    function automatic int len_field(input int n);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : n;
    endfunction

    task automatic put_key(input string s);
        put_len("$", len_field(s.len()));
        put_text({s, "\r\n"});
    endtask

    function automatic logic [7:0] value_byte();
        case ($urandom_range(0, 11))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'h2E;
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    task automatic put_value(input int n);
        put_len("$", len_field(n));
        repeat (n) add_byte(value_byte());
        put_text("\r\n");
    endtask

    function automatic string key_text();
        case ($urandom_range(0, 9))
            0:       return "IP";
            1:       return "ipp";
            2:       return "i";
            3:       return "porta";
            4:       return "PORT";
            5:       return "po";
            6:       return "name";
            7:       return "flags";
            8:       return "runid";
            default: return "pi";
        endcase
    endfunction

    task automatic queue_reply();
        for (int i = 0; i < reply_bytes.size(); i++)
            byte_q.insert(byte_q.size(),
                          t_in_item'{data_byte:    reply_bytes[i],
                                     end_of_reply: (i == reply_bytes.size() - 1)});
        reply_bytes.delete();
    endtask

    // mostly well-formed key/value replies, some noise and broken ones
    task automatic make_reply();
        int k;
        int keep;
        if ($urandom_range(0, 29) == 0) begin
            repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            k = $urandom_range(1, 8);
            case ($urandom_range(0, 19))
                0: begin
                    put_len("*", 0);
                    repeat ($urandom_range(0, 3))
                        add_byte(8'($urandom_range(0, 255)));
                    k = 0;
                end
                1:       put_len("*", $urandom_range(10, 300));
                default: put_len("*", 2 * k);
            endcase
            for (int i = 0; i < k; i++) begin
                case ($urandom_range(0, 9))
                    0: put_len("*", $urandom_range(0, 20));
                    1, 9: begin
                        put_key(key_text());
                        put_value($urandom_range(0, 8));
                    end
                    2, 3, 4: begin
                        put_key("ip");
                        put_value(($urandom_range(0, 7) == 0) ? $urandom_range(30, 70)
                                                              : $urandom_range(1, 15));
                    end
                    5, 6, 7: begin
                        put_key("port");
                        put_value(($urandom_range(0, 7) == 0) ? $urandom_range(30, 70)
                                                              : $urandom_range(1, 6));
                    end
                    default: put_value($urandom_range(0, 6));
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                reply_bytes[$urandom_range(0, reply_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 14) == 0) begin
                keep = $urandom_range(1, reply_bytes.size());
                while (reply_bytes.size() > keep)
                    void'(reply_bytes.pop_back());
            end
        end
        queue_reply();
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || i_valid || expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // driver and receiver stall, both change on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_fire) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    i_data  <= byte_q.pop_front();
                    i_valid <= 1'b1;
                    if (byte_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 14);
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (stall_gap > 0) begin
                i_stall   <= 1'b1;
                stall_gap <= stall_gap - 1;
            end else if (byte_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                i_stall   <= 1'b1;
                stall_gap <= $urandom_range(0, 13);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // monitor, prediction and watchdog
    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (!i_rst_n) begin
            in_fire     <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_fire <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    log_mismatch($sformatf("result %h with no transaction pending", o_data));
                end else begin
                    want = expected_q.pop_front();
                    if (o_data.addr_valid !== want.addr_valid)
                        log_mismatch($sformatf("addr_valid %b, want %b",
                                               o_data.addr_valid, want.addr_valid));
                    if (o_data.addr_char !== want.addr_char)
                        log_mismatch($sformatf("addr_char %h, want %h",
                                               o_data.addr_char, want.addr_char));
                    if (o_data.addr_complete !== want.addr_complete)
                        log_mismatch($sformatf("addr_complete %b, want %b",
                                               o_data.addr_complete, want.addr_complete));
                    if (o_data.end_status !== want.end_status)
                        log_mismatch($sformatf("end_status %0d, want %0d",
                                               o_data.end_status, want.end_status));
                end
            end
            if (i_valid && !o_stall)
                expected_q.insert(expected_q.size(), parse_byte(i_data));
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty array, lone bad bytes, then a short ip/port reply with a nested header
        put_text("*0\r\n");
        queue_reply();
        add_byte(8'hFF);
        queue_reply();
        add_byte(8'h00);
        queue_reply();
        put_text("*1\r\n*2\r\n$2\r\nip\r\n$1\r\n9\r\n$4\r\nport\r\n$1\r\n7\r\n");
        queue_reply();

        // sender holds off until every result is back
        wait_drained();

        while (byte_q.size() < 2000)
            make_reply();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
